// File: rtl/tlg_pkg.sv
// Shared types, codes and constants of the turtle line generator.
// No dependencies; every other file refers to it by scoped names.
package tlg_pkg;

    // Field widths of the channels
    localparam int OP_W       = 3;
    localparam int TURN_W     = 14;
    localparam int DIST_W     = 16;
    localparam int POS_W      = 18;
    localparam int HDG_W      = 16;
    localparam int START_H_W  = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // CORDIC datapath
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_DEPTH       = 24;
    localparam int ATAN_IDX_W       = 5;
    localparam int CX_W             = 48;
    localparam int Z_W              = 32;

    // Gain correction K in Q30 and the rounding half of Q30
    localparam logic signed [30:0] GAIN_Q30 = 31'sd652032874;
    localparam logic signed [CX_W-1:0] RND_HALF = 48'sd536870912;

    // Angle conversion: round(a * 1024 / 90) done as (a*1024 + 45) * ceil(2^31/90) >> 31
    localparam logic [23:0] CONV_BIAS = 24'd45;
    localparam logic [24:0] RECIP_90  = 25'd23860930;
    localparam int          RECIP_SH  = 31;

    // Command codes
    typedef enum logic [OP_W-1:0] {
        OP_RIGHT   = 3'd0,
        OP_LEFT    = 3'd1,
        OP_PEN     = 3'd2,
        OP_FORWARD = 3'd3,
        OP_RESTART = 3'd4
    } op_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_X   = 2'd0,
        REG_START_Y   = 2'd1,
        REG_START_HDG = 2'd2
    } reg_idx_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_CONV,
        ST_APPLY,
        ST_GAIN,
        ST_ITER,
        ST_ROUND,
        ST_UPDATE
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic set_pen;
        logic conv;
        logic apply;
        logic cordic_init;
        logic cordic_step;
        logic round;
        logic update;
    } ctrl_t;

    // Datapath to controller status
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            pen_lowered;
        logic            step_last;
        logic            out_full;
    } stat_t;

    // Arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [Z_W-1:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
        logic [Z_W-1:0] v;
        begin
            case (idx)
                5'd0:    v = 32'h20000000;
                5'd1:    v = 32'h12E4051E;
                5'd2:    v = 32'h09FB385B;
                5'd3:    v = 32'h051111D4;
                5'd4:    v = 32'h028B0D43;
                5'd5:    v = 32'h0145D7E1;
                5'd6:    v = 32'h00A2F61E;
                5'd7:    v = 32'h00517C55;
                5'd8:    v = 32'h0028BE53;
                5'd9:    v = 32'h00145F2F;
                5'd10:   v = 32'h000A2F98;
                5'd11:   v = 32'h000517CC;
                5'd12:   v = 32'h00028BE6;
                5'd13:   v = 32'h000145F3;
                5'd14:   v = 32'h0000A2FA;
                5'd15:   v = 32'h0000517D;
                5'd16:   v = 32'h000028BE;
                5'd17:   v = 32'h0000145F;
                5'd18:   v = 32'h00000A30;
                5'd19:   v = 32'h00000518;
                5'd20:   v = 32'h0000028C;
                5'd21:   v = 32'h00000146;
                5'd22:   v = 32'h000000A3;
                5'd23:   v = 32'h00000051;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

// File: rtl/tlg_intf.sv
// Channel interfaces of the turtle line generator: command, segment, config.
// Depends on tlg_pkg for field widths.
interface tlg_cmd_if;
    logic                              valid;
    logic                              ready;
    logic [tlg_pkg::OP_W-1:0]          op;
    logic signed [tlg_pkg::TURN_W-1:0] turn_amount;
    logic                              pen_state;
    logic signed [tlg_pkg::DIST_W-1:0] distance;

    modport source (output valid, op, turn_amount, pen_state, distance, input ready);
    modport sink   (input valid, op, turn_amount, pen_state, distance, output ready);
endinterface

interface tlg_seg_if;
    logic                             valid;
    logic                             ready;
    logic signed [tlg_pkg::POS_W-1:0] seg_start_x;
    logic signed [tlg_pkg::POS_W-1:0] seg_start_y;
    logic signed [tlg_pkg::POS_W-1:0] seg_end_x;
    logic signed [tlg_pkg::POS_W-1:0] seg_end_y;

    modport source (output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                    input ready);
    modport sink   (input valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                    output ready);
endinterface

interface tlg_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [tlg_pkg::CFG_IDX_W-1:0]     index;
    logic [tlg_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/turtle_line_generator.sv
// Top level of the turtle line generator: controller plus datapath.
// Depends on tlg_pkg, tlg_intf.sv, tlg_ctrl and tlg_datapath.
//
//   channel  dir  word                                          taken when
//   cmd      in   op, turn_amount, pen_state, distance          valid && ready
//   seg      out  seg_start_x/y, seg_end_x/y                    valid && ready
//   cfg      in   index, data (start_x, start_y, start_heading) valid (ready held high)
//
// One command at a time. Forward runs dispatch, gain, the CORDIC iterations
// (one rotation per cycle), round and update; turn and restart run dispatch,
// conversion and apply; set pen and unused codes take only dispatch.
// Reset restores pose (0, 0, facing up), pen up and the start registers.
// A forward with the pen down waits in its update state while the segment
// register still holds an untaken word; otherwise outputs never stall input.
module turtle_line_generator #(
    parameter int CORDIC_STEPS = tlg_pkg::CORDIC_STEPS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    tlg_cmd_if.sink   cmd,
    tlg_seg_if.source seg,
    tlg_cfg_if.sink   cfg
);

    tlg_pkg::ctrl_t ctl;
    tlg_pkg::stat_t sts;
    logic           cmd_ready;

    assign cmd.ready = cmd_ready;

    // Sequence each command
    tlg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_ready (cmd_ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    // Hold the pose and do the arithmetic
    tlg_datapath #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (cmd.op),
        .turn_amount (cmd.turn_amount),
        .pen_state   (cmd.pen_state),
        .distance    (cmd.distance),
        .cfg         (cfg),
        .seg         (seg),
        .ctl         (ctl),
        .sts         (sts)
    );

endmodule

// File: rtl/tlg_ctrl.sv
// Sequencing state machine of the turtle line generator.
// Depends on tlg_pkg (state, command and status types, op codes).
module tlg_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  tlg_pkg::stat_t sts,
    output tlg_pkg::ctrl_t ctl
);

    tlg_pkg::state_t state_reg;
    tlg_pkg::state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tlg_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Pick the next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tlg_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = tlg_pkg::ST_DISPATCH;
                end
            end
            tlg_pkg::ST_DISPATCH:
            begin
                if (sts.op inside {tlg_pkg::OP_RIGHT, tlg_pkg::OP_LEFT, tlg_pkg::OP_RESTART})
                begin
                    state_next = tlg_pkg::ST_CONV;
                end
                else if (sts.op == tlg_pkg::OP_FORWARD)
                begin
                    state_next = tlg_pkg::ST_GAIN;
                end
                else
                begin
                    state_next = tlg_pkg::ST_IDLE;
                end
            end
            tlg_pkg::ST_CONV:   state_next = tlg_pkg::ST_APPLY;
            tlg_pkg::ST_APPLY:  state_next = tlg_pkg::ST_IDLE;
            tlg_pkg::ST_GAIN:   state_next = tlg_pkg::ST_ITER;
            tlg_pkg::ST_ITER:
            begin
                if (sts.step_last)
                begin
                    state_next = tlg_pkg::ST_ROUND;
                end
            end
            tlg_pkg::ST_ROUND:  state_next = tlg_pkg::ST_UPDATE;
            tlg_pkg::ST_UPDATE:
            begin
                if (!(sts.pen_lowered && sts.out_full))
                begin
                    state_next = tlg_pkg::ST_IDLE;
                end
            end
            default:            state_next = tlg_pkg::ST_IDLE;
        endcase
    end

    // Drive commands for the current state
    always_comb
    begin
        ctl       = '0;
        cmd_ready = 1'b0;
        case (state_reg)
            tlg_pkg::ST_IDLE:
            begin
                cmd_ready   = 1'b1;
                ctl.load_in = cmd_valid;
            end
            tlg_pkg::ST_DISPATCH: ctl.set_pen     = (sts.op == tlg_pkg::OP_PEN);
            tlg_pkg::ST_CONV:     ctl.conv        = 1'b1;
            tlg_pkg::ST_APPLY:    ctl.apply       = 1'b1;
            tlg_pkg::ST_GAIN:     ctl.cordic_init = 1'b1;
            tlg_pkg::ST_ITER:     ctl.cordic_step = 1'b1;
            tlg_pkg::ST_ROUND:    ctl.round       = 1'b1;
            tlg_pkg::ST_UPDATE:   ctl.update      = !(sts.pen_lowered && sts.out_full);
            default:              ctl             = '0;
        endcase
    end

endmodule

// File: rtl/tlg_datapath.sv
// Datapath of the turtle line generator: pose registers, angle conversion,
// iterative CORDIC, saturation and the segment output register.
// Depends on tlg_pkg and the channel interfaces in tlg_intf.sv.
module tlg_datapath #(
    parameter int CORDIC_STEPS = tlg_pkg::CORDIC_STEPS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [tlg_pkg::OP_W-1:0]          op,
    input  logic signed [tlg_pkg::TURN_W-1:0] turn_amount,
    input  logic                              pen_state,
    input  logic signed [tlg_pkg::DIST_W-1:0] distance,
    tlg_cfg_if.sink                           cfg,
    tlg_seg_if.source                         seg,
    input  tlg_pkg::ctrl_t                    ctl,
    output tlg_pkg::stat_t                    sts
);

    localparam int POS_W  = tlg_pkg::POS_W;
    localparam int HDG_W  = tlg_pkg::HDG_W;
    localparam int CX_W   = tlg_pkg::CX_W;
    localparam int Z_W    = tlg_pkg::Z_W;
    localparam int TURN_W = tlg_pkg::TURN_W;
    localparam int DIST_W = tlg_pkg::DIST_W;
    localparam int AIW    = tlg_pkg::ATAN_IDX_W;
    localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);
    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

    // Clamp a sum one bit wider than a position to the position range
    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W:0] v);
        logic signed [POS_W-1:0] r;
        begin
            if (v[POS_W] != v[POS_W-1])
            begin
                r = v[POS_W] ? POS_MIN : POS_MAX;
            end
            else
            begin
                r = v[POS_W-1:0];
            end
            return r;
        end
    endfunction

    // Latched command word
    logic [tlg_pkg::OP_W-1:0]  op_reg;
    logic signed [TURN_W-1:0]  turn_reg;
    logic                      pen_in_reg;
    logic signed [DIST_W-1:0]  dist_reg;

    // Configuration and turtle state
    logic signed [tlg_pkg::CFG_DATA_W-1:0] start_x_reg;
    logic signed [tlg_pkg::CFG_DATA_W-1:0] start_y_reg;
    logic [tlg_pkg::START_H_W-1:0]         start_hdg_reg;
    logic signed [POS_W-1:0]               pos_x_reg;
    logic signed [POS_W-1:0]               pos_y_reg;
    logic [HDG_W-1:0]                      heading_reg;
    logic [HDG_W-1:0]                      heading_next;
    logic                                  pen_reg;

    // Angle conversion
    logic [TURN_W-1:0] conv_mag;
    logic              conv_neg;
    logic [23:0]       conv_num;
    logic [48:0]       conv_prod;
    logic [HDG_W-1:0]  conv_q_reg;
    logic              conv_neg_reg;
    logic [HDG_W-1:0]  bam;

    // CORDIC
    logic [HDG_W-1:0]         hdg_off;
    logic                     fold;
    logic signed [DIST_W:0]   d_ext;
    logic signed [DIST_W:0]   d_fold;
    logic signed [CX_W-1:0]   gain_prod;
    logic signed [CX_W-1:0]   cx_reg;
    logic signed [CX_W-1:0]   cy_reg;
    logic signed [CX_W-1:0]   cx_sh;
    logic signed [CX_W-1:0]   cy_sh;
    logic [Z_W-1:0]           z_reg;
    logic [Z_W-1:0]           atan_val;
    logic [STEP_W-1:0]        step_reg;
    logic signed [CX_W-1:0]   rnd_x;
    logic signed [CX_W-1:0]   rnd_y;
    logic signed [POS_W-1:0]  dx_reg;
    logic signed [POS_W-1:0]  dy_reg;
    logic signed [POS_W:0]    sum_x;
    logic signed [POS_W:0]    sum_y;
    logic signed [POS_W-1:0]  new_x;
    logic signed [POS_W-1:0]  new_y;

    // Segment output register
    logic                    seg_valid_reg;
    logic signed [POS_W-1:0] seg_sx_reg;
    logic signed [POS_W-1:0] seg_sy_reg;
    logic signed [POS_W-1:0] seg_ex_reg;
    logic signed [POS_W-1:0] seg_ey_reg;

    // Capture the accepted command word
    always_ff @(posedge clk)
    begin
        if (ctl.load_in)
        begin
            op_reg     <= op;
            turn_reg   <= turn_amount;
            pen_in_reg <= pen_state;
            dist_reg   <= distance;
        end
    end

    // Take configuration writes; indexes past the list are dropped
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg   <= '0;
            start_y_reg   <= '0;
            start_hdg_reg <= tlg_pkg::START_H_W'(1440);
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                tlg_pkg::REG_START_X:   start_x_reg   <= cfg.data;
                tlg_pkg::REG_START_Y:   start_y_reg   <= cfg.data;
                tlg_pkg::REG_START_HDG: start_hdg_reg <= cfg.data[tlg_pkg::START_H_W-1:0];
                default:                ;
            endcase
        end
    end

    // Convert 1/16 degree to binary angle: magnitude, bias, reciprocal multiply
    always_comb
    begin
        if (op_reg == tlg_pkg::OP_RESTART)
        begin
            conv_neg = 1'b0;
            conv_mag = {1'b0, start_hdg_reg};
        end
        else
        begin
            conv_neg = turn_reg[TURN_W-1];
            conv_mag = conv_neg ? (~turn_reg + 1'b1) : turn_reg;
        end
        conv_num  = {conv_mag, 10'd0} + tlg_pkg::CONV_BIAS;
        conv_prod = conv_num * tlg_pkg::RECIP_90;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.conv)
        begin
            conv_q_reg   <= conv_prod[tlg_pkg::RECIP_SH +: HDG_W];
            conv_neg_reg <= conv_neg;
        end
    end

    assign bam = conv_neg_reg ? (HDG_W'(0) - conv_q_reg) : conv_q_reg;

    // Work out the new heading for turn and restart
    always_comb
    begin
        case (op_reg)
            tlg_pkg::OP_RIGHT:   heading_next = heading_reg - bam;
            tlg_pkg::OP_LEFT:    heading_next = heading_reg + bam;
            tlg_pkg::OP_RESTART: heading_next = bam;
            default:             heading_next = heading_reg;
        endcase
    end

    // Fold the back half-plane into the front by negating the start vector
    assign hdg_off   = heading_reg + HDG_W'(16'h4000);
    assign fold      = hdg_off[HDG_W-1];
    assign d_ext     = {dist_reg[DIST_W-1], dist_reg};
    assign d_fold    = fold ? -d_ext : d_ext;
    assign gain_prod = d_fold * tlg_pkg::GAIN_Q30;

    // One micro-rotation per cycle
    assign cx_sh    = cx_reg >>> step_reg;
    assign cy_sh    = cy_reg >>> step_reg;
    assign atan_val = tlg_pkg::atan_turn(AIW'(step_reg));

    always_ff @(posedge clk)
    begin
        if (ctl.cordic_init)
        begin
            cx_reg   <= gain_prod;
            cy_reg   <= '0;
            z_reg    <= {heading_reg[HDG_W-1] ^ fold, heading_reg[HDG_W-2:0],
                         {(Z_W-HDG_W){1'b0}}};
            step_reg <= '0;
        end
        else if (ctl.cordic_step)
        begin
            if (!z_reg[Z_W-1])
            begin
                cx_reg <= cx_reg - cy_sh;
                cy_reg <= cy_reg + cx_sh;
                z_reg  <= z_reg - atan_val;
            end
            else
            begin
                cx_reg <= cx_reg + cy_sh;
                cy_reg <= cy_reg - cx_sh;
                z_reg  <= z_reg + atan_val;
            end
            step_reg <= step_reg + 1'b1;
        end
    end

    // Round Q30 back to the position unit
    assign rnd_x = cx_reg + tlg_pkg::RND_HALF;
    assign rnd_y = cy_reg + tlg_pkg::RND_HALF;

    always_ff @(posedge clk)
    begin
        if (ctl.round)
        begin
            dx_reg <= rnd_x[30 +: POS_W];
            dy_reg <= rnd_y[30 +: POS_W];
        end
    end

    // Add the step and saturate
    assign sum_x = {pos_x_reg[POS_W-1], pos_x_reg} + {dx_reg[POS_W-1], dx_reg};
    assign sum_y = {pos_y_reg[POS_W-1], pos_y_reg} + {dy_reg[POS_W-1], dy_reg};
    assign new_x = sat_pos(sum_x);
    assign new_y = sat_pos(sum_y);

    // Turtle state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            heading_reg <= HDG_W'(16384);
            pen_reg     <= 1'b0;
        end
        else
        begin
            if (ctl.set_pen)
            begin
                pen_reg <= pen_in_reg;
            end
            if (ctl.apply)
            begin
                heading_reg <= heading_next;
                if (op_reg == tlg_pkg::OP_RESTART)
                begin
                    pos_x_reg <= POS_W'(start_x_reg);
                    pos_y_reg <= POS_W'(start_y_reg);
                end
            end
            else if (ctl.update)
            begin
                pos_x_reg <= new_x;
                pos_y_reg <= new_y;
            end
        end
    end

    // Load the segment word with the pen down; drop valid when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_valid_reg <= 1'b0;
        end
        else if (ctl.update && pen_reg)
        begin
            seg_valid_reg <= 1'b1;
        end
        else if (seg.ready)
        begin
            seg_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.update && pen_reg)
        begin
            seg_sx_reg <= pos_x_reg;
            seg_sy_reg <= pos_y_reg;
            seg_ex_reg <= new_x;
            seg_ey_reg <= new_y;
        end
    end

    assign seg.valid       = seg_valid_reg;
    assign seg.seg_start_x = seg_sx_reg;
    assign seg.seg_start_y = seg_sy_reg;
    assign seg.seg_end_x   = seg_ex_reg;
    assign seg.seg_end_y   = seg_ey_reg;

    // Status back to the controller
    assign sts.op          = op_reg;
    assign sts.pen_lowered = pen_reg;
    assign sts.step_last   = (step_reg == STEP_LAST);
    assign sts.out_full    = seg_valid_reg && !seg.ready;

endmodule
